[hdl/assert_macros.svh]
// assertion macros shared by the timer rtl
// expects clk and rst (synchronous, active high) in the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising edge out of reset
`define CDT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cdt same-cycle check failed");

// next-cycle implication
`define CDT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cdt next-cycle check failed");

`endif

[hdl/cdt_pkg.sv]
// shared types and constants for the countdown timer with vectored interrupt
// no dependencies
`timescale 1ns / 1ps

package cdt_pkg;

  localparam int COUNT_BITS     = 24;
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = 8;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_ACK   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ACK_VECTOR   = 2'd0,
    ACK_AUTO     = 2'd1,
    ACK_SPURIOUS = 2'd2
  } ack_t;

  // register map
  localparam logic [3:0] REG_CONTROL   = 4'd0;
  localparam logic [3:0] REG_VECTOR    = 4'd1;
  localparam logic [3:0] REG_SPARE     = 4'd2;
  localparam logic [3:0] REG_PRELOAD_H = 4'd3;
  localparam logic [3:0] REG_PRELOAD_M = 4'd4;
  localparam logic [3:0] REG_PRELOAD_L = 4'd5;
  localparam logic [3:0] REG_COUNT_H   = 4'd6;
  localparam logic [3:0] REG_COUNT_M   = 4'd7;
  localparam logic [3:0] REG_COUNT_L   = 4'd8;
  localparam logic [3:0] REG_STATUS    = 4'd9;

  // configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TICK_STEP = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_IRQ_LEVEL = 1'd1;

  localparam logic [7:0] TICK_STEP_RESET = 8'd250;
  localparam logic [2:0] IRQ_LEVEL_RESET = 3'd5;

  // control mode field values that raise a request
  localparam logic [2:0] MODE_VECTORED = 3'd5;
  localparam logic [2:0] MODE_AUTO     = 3'd7;

  localparam logic [7:0] CTRL_ENABLE_CLEAR = 8'hfe;
  localparam logic [7:0] STATUS_EXPIRED    = 8'h01;

  typedef struct packed {
    cmd_t       cmd;
    logic [3:0] reg_sel;
    logic [7:0] write_data;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    ack_t       ack_code;
    logic       irq_pending;
    logic [2:0] irq_out_level;
  } result_t;

endpackage

[hdl/countdown_timer_with_vectored_irq.sv]
// top level of the countdown timer with vectored interrupt: input register,
// core and result register; depends on cdt_pkg, cdt_in_reg, cdt_exec, assert_macros.svh
//
//  channel | direction | handshake            | fields
//  --------+-----------+----------------------+-------------------------------------------
//  in      | input     | in_valid / in_stall  | cmd, reg_sel, write_data
//  out     | output    | out_valid / out_stall| read_data, ack_code, irq_pending, irq_out_level
//  cfg     | input     | cfg_write            | cfg_index, cfg_data
//
// one item per cycle sustained while out_stall is low; the result register is loaded
// as the core runs the item (the core updates its state and the result register together)
// the core is combinational between its registers: one 24-bit subtract and a byte decode
// a stalled result holds the result register; the input register still takes one item
// synchronous reset clears control, interrupt state and both valid flags, no clearing pass
`timescale 1ns / 1ps
`include "assert_macros.svh"

module countdown_timer_with_vectored_irq (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [cdt_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [cdt_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         cmd,
  input  logic [3:0]                         reg_sel,
  input  logic [7:0]                         write_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [7:0]                         read_data,
  output logic [1:0]                         ack_code,
  output logic                               irq_pending,
  output logic [2:0]                         irq_out_level
);

  logic             item_valid;
  logic             advance;
  cdt_pkg::item_t   item;
  cdt_pkg::result_t result;

  // the core runs an item when the result register is free or being emptied
  assign advance = item_valid && (!out_valid || !out_stall);

  cdt_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .reg_sel    (reg_sel),
    .write_data (write_data),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  cdt_exec u_exec (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (advance),
    .item      (item),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      read_data     <= result.read_data;
      ack_code      <= 2'(result.ack_code);
      irq_pending   <= result.irq_pending;
      irq_out_level <= result.irq_out_level;
    end
  end

  `CDT_ASSERT_NOW(a_stall_means_full, in_stall, item_valid && out_valid && out_stall)
  `CDT_ASSERT_NOW(a_level_only_pending, out_valid && !irq_pending, irq_out_level == 3'd0)
  `CDT_ASSERT_NEXT(a_advance_fills_out, advance, out_valid)

endmodule

[hdl/cdt_in_reg.sv]
// input register of the timer: holds one accepted item until the core takes it
// depends on cdt_pkg
`timescale 1ns / 1ps

module cdt_in_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [1:0]     cmd,
  input  logic [3:0]     reg_sel,
  input  logic [7:0]     write_data,
  input  logic           advance,
  output logic           item_valid,
  output cdt_pkg::item_t item
);

  logic load;

  // the slot frees up in the same cycle the core consumes its item
  assign load     = !item_valid || advance;
  assign in_stall = !load;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (load) begin
      item_valid <= in_valid;
    end
    if (load && in_valid) begin
      item.cmd        <= cdt_pkg::cmd_t'(cmd);
      item.reg_sel    <= reg_sel;
      item.write_data <= write_data;
    end
  end

endmodule

[hdl/cdt_exec.sv]
// timer core: register file, counter, interrupt state and result logic
// depends on cdt_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cdt_exec (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [cdt_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [cdt_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  logic                                 fire,
  input  cdt_pkg::item_t                       item,
  output cdt_pkg::result_t                     result
);

  localparam int CB = cdt_pkg::COUNT_BITS;

  logic [7:0]    tick_step;
  logic [2:0]    irq_level;

  logic [7:0]    control_byte, control_byte_next;
  logic [7:0]    vector_byte, vector_byte_next;
  logic [7:0]    spare_byte, spare_byte_next;
  logic [CB-1:0] preload_value, preload_value_next;
  logic [CB-1:0] count_value, count_value_next;
  logic [7:0]    status_byte, status_byte_next;
  logic          load_needed, load_needed_next;
  logic          pending_flag, pending_flag_next;

  logic [31:0]   preload_wide, preload_upd, count_wide;
  logic [CB-1:0] step_ext, base, count_sub;
  logic [CB:0]   diff;
  logic [2:0]    mode;
  logic [7:0]    rd;
  cdt_pkg::ack_t code;

  assign preload_wide = 32'(preload_value);
  assign count_wide   = 32'(count_value);
  assign mode         = control_byte[7:5];

  // counter step: first enabled tick after reset or expiry starts from the preload
  assign step_ext  = CB'(tick_step);
  assign base      = load_needed ? preload_value : count_value;
  assign diff      = {1'b0, base} - {1'b0, step_ext};
  assign count_sub = diff[CB] ? '0 : diff[CB-1:0];

  always_comb begin
    control_byte_next  = control_byte;
    vector_byte_next   = vector_byte;
    spare_byte_next    = spare_byte;
    preload_value_next = preload_value;
    count_value_next   = count_value;
    status_byte_next   = status_byte;
    load_needed_next   = load_needed;
    pending_flag_next  = pending_flag;
    preload_upd        = preload_wide;
    rd                 = 8'd0;
    code               = cdt_pkg::ACK_VECTOR;

    case (item.cmd)
      cdt_pkg::CMD_READ: begin
        unique case (item.reg_sel)
          cdt_pkg::REG_CONTROL:   rd = control_byte;
          cdt_pkg::REG_VECTOR:    rd = vector_byte;
          cdt_pkg::REG_SPARE:     rd = spare_byte;
          cdt_pkg::REG_PRELOAD_H: rd = preload_wide[23:16];
          cdt_pkg::REG_PRELOAD_M: rd = preload_wide[15:8];
          cdt_pkg::REG_PRELOAD_L: rd = preload_wide[7:0];
          cdt_pkg::REG_COUNT_H:   rd = count_wide[23:16];
          cdt_pkg::REG_COUNT_M:   rd = count_wide[15:8];
          cdt_pkg::REG_COUNT_L:   rd = count_wide[7:0];
          cdt_pkg::REG_STATUS:    rd = status_byte;
          default:                rd = 8'd0;
        endcase
      end
      cdt_pkg::CMD_WRITE: begin
        unique case (item.reg_sel)
          cdt_pkg::REG_CONTROL:   control_byte_next = item.write_data;
          cdt_pkg::REG_VECTOR:    vector_byte_next  = item.write_data;
          cdt_pkg::REG_SPARE:     spare_byte_next   = item.write_data;
          cdt_pkg::REG_PRELOAD_H: preload_upd[23:16] = item.write_data;
          cdt_pkg::REG_PRELOAD_M: preload_upd[15:8]  = item.write_data;
          cdt_pkg::REG_PRELOAD_L: preload_upd[7:0]   = item.write_data;
          cdt_pkg::REG_STATUS:    status_byte_next  = item.write_data;
          default:                ;
        endcase
        preload_value_next = preload_upd[CB-1:0];
      end
      cdt_pkg::CMD_TICK: begin
        if (control_byte[0]) begin
          load_needed_next = 1'b0;
          count_value_next = count_sub;
          if (count_sub == '0) begin
            load_needed_next  = 1'b1;
            control_byte_next = control_byte & cdt_pkg::CTRL_ENABLE_CLEAR;
            status_byte_next  = status_byte | cdt_pkg::STATUS_EXPIRED;
            if (mode == cdt_pkg::MODE_VECTORED || mode == cdt_pkg::MODE_AUTO) begin
              pending_flag_next = 1'b1;
            end
          end
        end
      end
      default: begin
        // interrupt acknowledge
        code = cdt_pkg::ACK_SPURIOUS;
        if (pending_flag) begin
          if (mode == cdt_pkg::MODE_VECTORED) begin
            pending_flag_next = 1'b0;
            rd                = vector_byte;
            code              = cdt_pkg::ACK_VECTOR;
          end else if (mode == cdt_pkg::MODE_AUTO) begin
            pending_flag_next = 1'b0;
            code              = cdt_pkg::ACK_AUTO;
          end
        end
      end
    endcase

    result.read_data     = rd;
    result.ack_code      = code;
    result.irq_pending   = pending_flag_next;
    result.irq_out_level = pending_flag_next ? irq_level : 3'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_step     <= cdt_pkg::TICK_STEP_RESET;
      irq_level     <= cdt_pkg::IRQ_LEVEL_RESET;
      control_byte  <= 8'd0;
      vector_byte   <= 8'd0;
      spare_byte    <= 8'd0;
      preload_value <= '0;
      count_value   <= '0;
      status_byte   <= 8'd0;
      load_needed   <= 1'b1;
      pending_flag  <= 1'b0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == cdt_pkg::CFG_TICK_STEP) begin
          tick_step <= cfg_data[7:0];
        end else if (cfg_index == cdt_pkg::CFG_IRQ_LEVEL) begin
          irq_level <= cfg_data[2:0];
        end
      end
      if (fire) begin
        control_byte  <= control_byte_next;
        vector_byte   <= vector_byte_next;
        spare_byte    <= spare_byte_next;
        preload_value <= preload_value_next;
        count_value   <= count_value_next;
        status_byte   <= status_byte_next;
        load_needed   <= load_needed_next;
        pending_flag  <= pending_flag_next;
      end
    end
  end

  `CDT_ASSERT_NEXT(a_disabled_tick_holds, fire && item.cmd == cdt_pkg::CMD_TICK && !control_byte[0], $stable(count_value) && $stable(pending_flag))
  `CDT_ASSERT_NEXT(a_count_only_falls, fire && item.cmd == cdt_pkg::CMD_TICK && !load_needed, count_value <= $past(count_value))
  `CDT_ASSERT_NEXT(a_spurious_keeps_idle, fire && item.cmd == cdt_pkg::CMD_ACK && !pending_flag, !pending_flag)
  `CDT_ASSERT_NOW(a_expiry_reloads, fire && item.cmd == cdt_pkg::CMD_TICK && control_byte[0] && count_sub == '0, load_needed_next && pending_flag_next == (pending_flag || mode == cdt_pkg::MODE_VECTORED || mode == cdt_pkg::MODE_AUTO))

endmodule

[test/tb_countdown_timer_with_vectored_irq.sv]
// testbench for countdown_timer_with_vectored_irq: directed and random bus traffic
// checked against a timer predictor; depends on cdt_pkg and the timer rtl
`timescale 1ns / 1ps

module tb_countdown_timer_with_vectored_irq;

  logic                               clk;
  logic                               rst;
  logic                               cfg_write;
  logic [cdt_pkg::CFG_INDEX_BITS-1:0] cfg_index;
  logic [cdt_pkg::CFG_DATA_BITS-1:0]  cfg_data;
  logic                               in_valid;
  logic                               in_stall;
  logic [1:0]                         cmd;
  logic [3:0]                         reg_sel;
  logic [7:0]                         write_data;
  logic                               out_valid;
  logic                               out_stall;
  logic [7:0]                         read_data;
  logic [1:0]                         ack_code;
  logic                               irq_pending;
  logic [2:0]                         irq_out_level;

  countdown_timer_with_vectored_irq dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .cmd(cmd),
    .reg_sel(reg_sel),
    .write_data(write_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .read_data(read_data),
    .ack_code(ack_code),
    .irq_pending(irq_pending),
    .irq_out_level(irq_out_level)
  );

  // predicted timer state
  logic [7:0]                     ctrl_q;
  logic [7:0]                     vec_q;
  logic [7:0]                     spare_q;
  logic [cdt_pkg::COUNT_BITS-1:0] preload_q;
  logic [cdt_pkg::COUNT_BITS-1:0] count_q;
  logic [7:0]                     status_q;
  logic                           load_q;
  logic                           pend_q;
  logic [7:0]                     step_q;
  logic [2:0]                     level_q;

  cdt_pkg::result_t expected_results[$];
  int      mismatches = 0;
  int      items_sent = 0;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;

  always #4 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  task automatic timer_step(input cdt_pkg::item_t it, output cdt_pkg::result_t res);
    logic [2:0] mode;
    res = '0;
    res.ack_code = cdt_pkg::ACK_VECTOR;
    mode = ctrl_q[7:5];
    case (it.cmd)
      cdt_pkg::CMD_READ: begin
        case (it.reg_sel)
          cdt_pkg::REG_CONTROL:   res.read_data = ctrl_q;
          cdt_pkg::REG_VECTOR:    res.read_data = vec_q;
          cdt_pkg::REG_SPARE:     res.read_data = spare_q;
          cdt_pkg::REG_PRELOAD_H: res.read_data = preload_q[23:16];
          cdt_pkg::REG_PRELOAD_M: res.read_data = preload_q[15:8];
          cdt_pkg::REG_PRELOAD_L: res.read_data = preload_q[7:0];
          cdt_pkg::REG_COUNT_H:   res.read_data = count_q[23:16];
          cdt_pkg::REG_COUNT_M:   res.read_data = count_q[15:8];
          cdt_pkg::REG_COUNT_L:   res.read_data = count_q[7:0];
          cdt_pkg::REG_STATUS:    res.read_data = status_q;
          default:                res.read_data = 8'd0;
        endcase
      end
      cdt_pkg::CMD_WRITE: begin
        case (it.reg_sel)
          cdt_pkg::REG_CONTROL:   ctrl_q = it.write_data;
          cdt_pkg::REG_VECTOR:    vec_q = it.write_data;
          cdt_pkg::REG_SPARE:     spare_q = it.write_data;
          cdt_pkg::REG_PRELOAD_H: preload_q[23:16] = it.write_data;
          cdt_pkg::REG_PRELOAD_M: preload_q[15:8] = it.write_data;
          cdt_pkg::REG_PRELOAD_L: preload_q[7:0] = it.write_data;
          cdt_pkg::REG_STATUS:    status_q = it.write_data;
          default: ;
        endcase
      end
      cdt_pkg::CMD_TICK: begin
        if (ctrl_q[0]) begin
          if (load_q) begin
            load_q = 1'b0;
            count_q = preload_q;
          end
          count_q = (count_q >= step_q) ? count_q - step_q : '0;
          if (count_q == '0) begin
            load_q = 1'b1;
            ctrl_q = ctrl_q & cdt_pkg::CTRL_ENABLE_CLEAR;
            status_q = status_q | cdt_pkg::STATUS_EXPIRED;
            if (mode == cdt_pkg::MODE_VECTORED || mode == cdt_pkg::MODE_AUTO) pend_q = 1'b1;
          end
        end
      end
      default: begin
        res.ack_code = cdt_pkg::ACK_SPURIOUS;
        if (pend_q && mode == cdt_pkg::MODE_VECTORED) begin
          pend_q = 1'b0;
          res.read_data = vec_q;
          res.ack_code = cdt_pkg::ACK_VECTOR;
        end else if (pend_q && mode == cdt_pkg::MODE_AUTO) begin
          pend_q = 1'b0;
          res.ack_code = cdt_pkg::ACK_AUTO;
        end
      end
    endcase
    res.irq_pending = pend_q;
    res.irq_out_level = pend_q ? level_q : 3'd0;
  endtask

  // predict at input acceptance, compare at output acceptance
  always @(posedge clk) begin : result_check
    cdt_pkg::item_t   it;
    cdt_pkg::result_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        it.cmd = cdt_pkg::cmd_t'(cmd);
        it.reg_sel = reg_sel;
        it.write_data = write_data;
        timer_step(it, want);
        expected_results.push_back(want);
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected item: read_data %0h ack_code %0d irq_pending %0b level %0d",
                   $time, read_data, ack_code, irq_pending, irq_out_level);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (read_data !== want.read_data) begin
            $display("%0t: read_data expected %0h actual %0h", $time, want.read_data, read_data);
            mismatches++;
          end
          if (ack_code !== want.ack_code) begin
            $display("%0t: ack_code expected %0d actual %0d", $time, want.ack_code, ack_code);
            mismatches++;
          end
          if (irq_pending !== want.irq_pending) begin
            $display("%0t: irq_pending expected %0b actual %0b", $time, want.irq_pending,
                     irq_pending);
            mismatches++;
          end
          if (irq_out_level !== want.irq_out_level) begin
            $display("%0t: irq_out_level expected %0d actual %0d", $time, want.irq_out_level,
                     irq_out_level);
            mismatches++;
          end
        end
      end
    end
  end

  task automatic send_item(input cdt_pkg::cmd_t c, input logic [3:0] sel,
                           input logic [7:0] data);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    cmd <= c;
    reg_sel <= sel;
    write_data <= data;
    do @(posedge clk); while (in_stall !== 1'b0);
    items_sent++;
  endtask

  // drop valid, let every outstanding item drain, then let the bus sit idle
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] step, input logic [2:0] level);
    cfg_write <= 1'b1;
    cfg_index <= cdt_pkg::CFG_TICK_STEP;
    cfg_data <= step;
    @(posedge clk);
    cfg_index <= cdt_pkg::CFG_IRQ_LEVEL;
    cfg_data <= {5'd0, level};
    @(posedge clk);
    cfg_write <= 1'b0;
    step_q = step;
    level_q = level;
  endtask

  // program preload and mode, run one to eight ticks with reads mixed in, then up to two acknowledges
  task automatic run_timer_sequence();
    logic [23:0] pre;
    logic [2:0]  mode;
    int          ticks;
    int          pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) pre = 24'($urandom);
    else if (pick == 1) pre = '0;
    else pre = 24'($urandom_range(0, step_q * 5 + 3));
    pick = $urandom_range(0, 9);
    if (pick < 4) mode = cdt_pkg::MODE_VECTORED;
    else if (pick < 8) mode = cdt_pkg::MODE_AUTO;
    else mode = 3'($urandom);
    if ($urandom_range(0, 3) != 0) send_item(cdt_pkg::CMD_WRITE, cdt_pkg::REG_PRELOAD_H, pre[23:16]);
    if ($urandom_range(0, 3) != 0) send_item(cdt_pkg::CMD_WRITE, cdt_pkg::REG_PRELOAD_M, pre[15:8]);
    send_item(cdt_pkg::CMD_WRITE, cdt_pkg::REG_PRELOAD_L, pre[7:0]);
    if ($urandom_range(0, 1) == 0) send_item(cdt_pkg::CMD_WRITE, cdt_pkg::REG_VECTOR, 8'($urandom));
    send_item(cdt_pkg::CMD_WRITE, cdt_pkg::REG_CONTROL, {mode, 4'($urandom), 1'b1});
    ticks = $urandom_range(1, 8);
    repeat (ticks) begin
      send_item(cdt_pkg::CMD_TICK, 4'($urandom), 8'($urandom));
      if ($urandom_range(0, 2) == 0) begin
        if ($urandom_range(0, 1) == 0)
          send_item(cdt_pkg::CMD_READ, 4'($urandom_range(6, 9)), 8'($urandom));
        else send_item(cdt_pkg::CMD_READ, 4'($urandom), 8'($urandom));
      end
    end
    repeat ($urandom_range(0, 2)) send_item(cdt_pkg::CMD_ACK, 4'($urandom), 8'($urandom));
    if ($urandom_range(0, 3) == 0) send_item(cdt_pkg::CMD_WRITE, cdt_pkg::REG_STATUS, 8'($urandom));
  endtask

  task automatic random_items(input int n);
    int target;
    target = items_sent + n;
    while (items_sent < target) begin
      if ($urandom_range(0, 9) < 7) run_timer_sequence();
      else send_item(cdt_pkg::cmd_t'($urandom_range(0, 3)), 4'($urandom), 8'($urandom));
    end
  endtask

  task automatic test_register_access();
    send_item(cdt_pkg::CMD_WRITE, cdt_pkg::REG_VECTOR, 8'hff);
    send_item(cdt_pkg::CMD_WRITE, cdt_pkg::REG_SPARE, 8'hff);
    send_item(cdt_pkg::CMD_WRITE, cdt_pkg::REG_PRELOAD_H, 8'hff);
    send_item(cdt_pkg::CMD_WRITE, cdt_pkg::REG_COUNT_L, 8'hff);
    send_item(cdt_pkg::CMD_WRITE, 4'hf, 8'hff);
    send_item(cdt_pkg::CMD_WRITE, cdt_pkg::REG_STATUS, 8'hfe);
    send_item(cdt_pkg::CMD_READ, cdt_pkg::REG_VECTOR, 8'h00);
    send_item(cdt_pkg::CMD_READ, cdt_pkg::REG_SPARE, 8'h00);
    send_item(cdt_pkg::CMD_READ, cdt_pkg::REG_PRELOAD_H, 8'h00);
    send_item(cdt_pkg::CMD_READ, cdt_pkg::REG_COUNT_L, 8'h00);
    send_item(cdt_pkg::CMD_READ, 4'hf, 8'h00);
    send_item(cdt_pkg::CMD_READ, cdt_pkg::REG_STATUS, 8'h00);
  endtask

  task automatic test_timer_expiry();
    // preload 256 expires on the second tick at the reset step
    send_item(cdt_pkg::CMD_WRITE, cdt_pkg::REG_PRELOAD_H, 8'h00);
    send_item(cdt_pkg::CMD_WRITE, cdt_pkg::REG_PRELOAD_M, 8'h01);
    send_item(cdt_pkg::CMD_WRITE, cdt_pkg::REG_PRELOAD_L, 8'h00);
    send_item(cdt_pkg::CMD_ACK, 4'h0, 8'h00);
    send_item(cdt_pkg::CMD_WRITE, cdt_pkg::REG_CONTROL, {cdt_pkg::MODE_VECTORED, 4'b0000, 1'b1});
    send_item(cdt_pkg::CMD_TICK, 4'h0, 8'h00);
    send_item(cdt_pkg::CMD_TICK, 4'h0, 8'h00);
    // request stays while mode is neither vectored nor auto
    send_item(cdt_pkg::CMD_WRITE, cdt_pkg::REG_CONTROL, {3'd3, 4'b0000, 1'b0});
    send_item(cdt_pkg::CMD_ACK, 4'h0, 8'h00);
    send_item(cdt_pkg::CMD_TICK, 4'h0, 8'h00);
    send_item(cdt_pkg::CMD_WRITE, cdt_pkg::REG_CONTROL, {cdt_pkg::MODE_VECTORED, 4'b0000, 1'b0});
    send_item(cdt_pkg::CMD_ACK, 4'h0, 8'h00);
    send_item(cdt_pkg::CMD_WRITE, cdt_pkg::REG_CONTROL, {cdt_pkg::MODE_AUTO, 4'b0000, 1'b1});
    send_item(cdt_pkg::CMD_TICK, 4'h0, 8'h00);
    send_item(cdt_pkg::CMD_TICK, 4'h0, 8'h00);
    send_item(cdt_pkg::CMD_ACK, 4'h0, 8'h00);
    send_item(cdt_pkg::CMD_ACK, 4'h0, 8'h00);
  endtask

  task automatic test_zero_step_and_level();
    settle();
    set_config(8'd0, 3'd0);
    // a zero preload fires on the first tick if a reload is due, though the counter never moves
    send_item(cdt_pkg::CMD_WRITE, cdt_pkg::REG_PRELOAD_H, 8'h00);
    send_item(cdt_pkg::CMD_WRITE, cdt_pkg::REG_PRELOAD_M, 8'h00);
    send_item(cdt_pkg::CMD_WRITE, cdt_pkg::REG_PRELOAD_L, 8'h00);
    send_item(cdt_pkg::CMD_WRITE, cdt_pkg::REG_CONTROL, {cdt_pkg::MODE_AUTO, 4'b0000, 1'b1});
    send_item(cdt_pkg::CMD_TICK, 4'h0, 8'h00);
    send_item(cdt_pkg::CMD_ACK, 4'h0, 8'h00);
    random_items(150);
  endtask

  task automatic test_random_traffic(input logic [7:0] step, input logic [2:0] level,
                                     input int n);
    settle();
    set_config(step, level);
    random_items(n);
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    cmd = '0;
    reg_sel = '0;
    write_data = '0;
    out_stall = 1'b0;
    ctrl_q = '0;
    vec_q = '0;
    spare_q = '0;
    preload_q = '0;
    count_q = '0;
    status_q = '0;
    load_q = 1'b1;
    pend_q = 1'b0;
    step_q = cdt_pkg::TICK_STEP_RESET;
    level_q = cdt_pkg::IRQ_LEVEL_RESET;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 29;
    recv_idle_pct = 63;
    test_register_access();
    test_timer_expiry();
    test_random_traffic(8'd1, 3'd7, 450);

    send_idle_pct = 63;
    recv_idle_pct = 29;
    test_random_traffic(8'd255, 3'd1, 450);
    test_random_traffic(8'($urandom_range(2, 254)), 3'($urandom_range(1, 7)), 450);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_zero_step_and_level();
    test_random_traffic(cdt_pkg::TICK_STEP_RESET, cdt_pkg::IRQ_LEVEL_RESET, 400);

    settle();
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
